// ===== rtl/cnv3_pkg.sv =====
// Shared constants and types for the 3x3 RGB convolution block.
package cnv3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int COEFF_BITS_DEF = 8;
   localparam int PIX_W          = 24;
   localparam int FW_W           = 11;
   localparam int FH_W           = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_DEF   = 24;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
   localparam int              KERNEL_MID_RST   = 256;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic ends;
      logic col_zero;
      logic col_one;
      logic draining;
   } ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
      ctl_type          ctl;
   } ent_type;

endpackage

// ===== rtl/cnv3_ifaces.sv =====
// Channel interfaces: pixel requests, filtered responses, register writes.
interface cnv3_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   modport source (output valid, operation, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink (input valid, operation, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface cnv3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       row_end;
   logic       frame_end;
   logic       run_last;
   modport source (output valid, out_red, out_green, out_blue, row_end, frame_end, run_last,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, row_end, frame_end, run_last,
                 output ready);
endinterface

interface cnv3_csr_if #(parameter int DATA_W = 24);
   logic              valid;
   logic              ready;
   logic [2:0]        index;
   logic [DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/conv3x3_rgb_clamp_edge.sv =====
// Top level: 3x3 RGB convolution with edge replication and clamping.
// A beat's results pass through the front-end stage, the queue, then the window, job, product and output registers.
// Throughput: one beat per cycle while the queue has room; a beat yielding two results holds back the next entry.
// Line stores share one memory, read once per beat and written once per pixel.
// Reset (synchronous, active high) clears counters, queue and pipeline valids and
// loads width 640, height 480 and the identity kernel; line stores are not cleared.
module conv3x3_rgb_clamp_edge
   import cnv3_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int COEFF_BITS = COEFF_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cnv3_req_if.sink   req_ch,
   cnv3_rsp_if.source rsp_ch,
   cnv3_csr_if.sink   csr_ch
);
   localparam int KW = 3 * COEFF_BITS;

   logic [FW_W-1:0]       fw_ff;
   logic [FH_W-1:0]       fh_ff;
   logic [2:0][KW-1:0]    kern_ff;
   logic                  push, pop, q_valid;
   ent_type               push_ent, q_ent;
   logic [QCNT_W-1:0]     q_count;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= FRAME_WIDTH_RST;
         fh_ff      <= FRAME_HEIGHT_RST;
         kern_ff[0] <= '0;
         kern_ff[1] <= KW'(KERNEL_MID_RST);
         kern_ff[2] <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FRAME_WIDTH:   fw_ff      <= FW_W'(csr_ch.data);
            REG_FRAME_HEIGHT:  fh_ff      <= FH_W'(csr_ch.data);
            REG_KERNEL_TOP:    kern_ff[0] <= KW'(csr_ch.data);
            REG_KERNEL_MIDDLE: kern_ff[1] <= KW'(csr_ch.data);
            REG_KERNEL_BOTTOM: kern_ff[2] <= KW'(csr_ch.data);
            default: ;
         endcase
      end
   end

   cnv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .frame_width  (fw_ff),
      .frame_height (fh_ff),
      .q_count      (q_count),
      .push         (push),
      .push_ent     (push_ent)
   );

   cnv3_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_ent    (q_ent),
      .q_count  (q_count)
   );

   cnv3_back #(.COEFF_BITS(COEFF_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ent   (q_ent),
      .pop     (pop),
      .kernel  (kern_ff),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== rtl/cnv3_front.sv =====
// Front end: accepts beats, tracks row/column, line store access, queue push.
module cnv3_front
   import cnv3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cnv3_req_if.sink          req_ch,
   input  logic [FW_W-1:0]   frame_width,
   input  logic [FH_W-1:0]   frame_height,
   input  logic [QCNT_W-1:0] q_count,
   output logic              push,
   output ent_type           push_ent
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = (FW_W > AW + 1) ? FW_W : AW + 1;
   localparam int MW = 2 * PIX_W;

   logic [MW-1:0]    mem [MAX_WIDTH];
   logic [AW-1:0]    col_ff, col_in, drn_ff, drn_in;
   logic [FH_W-1:0]  row_ff, row_in;
   logic             s1_v_ff, s1_wr_ff, s1_emit_ff, s1_dup_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [PIX_W-1:0] s1_px_ff;
   ctl_type          s1_ctl_ff, ctl_in;
   logic [MW-1:0]    rd_q_ff, byp_d_ff, cur;
   logic             byp_v_ff;
   logic [EW-1:0]    fw_ext, w_eff;
   logic [AW-1:0]    wm1, addr;
   logic [FH_W-1:0]  h_eff;
   logic             acc, is_drain, live, ends;
   logic [PIX_W-1:0] px, upper, lower;

   always_comb begin
      fw_ext = EW'(frame_width);
      if (fw_ext == '0) begin
         w_eff = EW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      wm1 = AW'(w_eff - EW'(1));
      h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
   end

   assign req_ch.ready = ({1'b0, q_count} + (QCNT_W + 1)'(s1_v_ff)) < (QCNT_W + 1)'(QUEUE_DEPTH);
   assign acc      = req_ch.valid && req_ch.ready;
   assign is_drain = req_ch.operation == OP_DRAIN;
   assign live     = is_drain ? (row_ff >= h_eff) : (row_ff < h_eff);
   assign addr     = is_drain ? drn_ff : col_ff;
   assign ends     = addr >= wm1;
   assign px       = {req_ch.pixel_blue, req_ch.pixel_green, req_ch.pixel_red};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      drn_in = drn_ff;
      ctl_in = '{ends: ends, col_zero: addr == '0, col_one: addr == AW'(1),
                 draining: is_drain};
      if (acc && live) begin
         if (!is_drain) begin
            if (ends) begin
               col_in = '0;
               row_in = row_ff + FH_W'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
         end else begin
            if (ends) begin
               col_in = '0;
               row_in = '0;
               drn_in = '0;
            end else begin
               drn_in = drn_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drn_ff   <= '0;
         s1_v_ff  <= 1'b0;
         byp_v_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drn_ff   <= drn_in;
         s1_v_ff  <= acc && live;
         byp_v_ff <= s1_v_ff && s1_wr_ff && (addr == s1_addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (acc && live) begin
         s1_addr_ff <= addr;
         s1_px_ff   <= px;
         s1_wr_ff   <= !is_drain;
         s1_emit_ff <= is_drain || (row_ff != '0);
         s1_dup_ff  <= is_drain ? (row_ff <= FH_W'(1)) : (row_ff == FH_W'(1));
         s1_ctl_ff  <= ctl_in;
         rd_q_ff    <= mem[addr];
      end
      byp_d_ff <= {lower, s1_px_ff};
      if (s1_v_ff && s1_wr_ff) begin
         mem[s1_addr_ff] <= {lower, s1_px_ff};
      end
   end

   assign cur   = byp_v_ff ? byp_d_ff : rd_q_ff;
   assign upper = cur[MW-1:PIX_W];
   assign lower = cur[PIX_W-1:0];

   assign push         = s1_v_ff && s1_emit_ff;
   assign push_ent.top = s1_dup_ff ? lower : upper;
   assign push_ent.mid = lower;
   assign push_ent.bot = s1_wr_ff ? s1_px_ff : lower;
   assign push_ent.ctl = s1_ctl_ff;

endmodule

// ===== rtl/cnv3_fifo.sv =====
// Short queue of column entries between front and back ends.
module cnv3_fifo
   import cnv3_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ent_type           push_ent,
   input  logic              pop,
   output logic              q_valid,
   output ent_type           q_ent,
   output logic [QCNT_W-1:0] q_count
);
   localparam int PW = $clog2(QUEUE_DEPTH);

   ent_type           store [QUEUE_DEPTH];
   logic [PW-1:0]     wp_ff, rp_ff;
   logic [QCNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + PW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wp_ff] <= push_ent;
      end
   end

   assign q_valid = cnt_ff != '0;
   assign q_ent   = store[rp_ff];
   assign q_count = cnt_ff;

endmodule

// ===== rtl/cnv3_back.sv =====
// Back end: 3x3 window, result sequencing, multiply, sum, clamp, output register.
module cnv3_back
   import cnv3_pkg::*;
#(
   parameter int COEFF_BITS = COEFF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  ent_type                             q_ent,
   output logic                                pop,
   input  logic [2:0][3*COEFF_BITS-1:0]        kernel,
   cnv3_rsp_if.source                          rsp_ch
);
   localparam int PW = COEFF_BITS + 9;
   localparam int SW = PW + 4;

   logic [PIX_W-1:0]   win_ff [3][3];
   logic [PIX_W-1:0]   job_ff [3][3];
   logic [PIX_W-1:0]   job_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3][3];
   logic signed [PW-1:0] prod_in [3][3][3];
   logic signed [COEFF_BITS-1:0] kc [3][3];
   logic signed [SW-1:0] sum [3];
   logic [7:0]         clamp [3];
   logic               cur_v_ff, need_a_ff, need_b_ff, col_zero_ff, col_one_ff, drain_ff;
   logic               job_v_ff, job_rend_ff, job_fend_ff, job_last_ff;
   logic               prod_v_ff, prod_rend_ff, prod_fend_ff, prod_last_ff;
   logic               out_v_ff, out_rend_ff, out_fend_ff, out_last_ff;
   logic [7:0]         out_r_ff, out_g_ff, out_b_ff;
   logic               adv, finishing, job_go;

   assign adv       = !out_v_ff || rsp_ch.ready;
   assign finishing = !cur_v_ff || !(need_a_ff && need_b_ff);
   assign pop       = adv && q_valid && finishing;
   assign job_go    = cur_v_ff && (need_a_ff || need_b_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (need_a_ff) begin
            job_in[0][i] = col_one_ff ? win_ff[1][i] : win_ff[0][i];
            job_in[1][i] = win_ff[1][i];
            job_in[2][i] = win_ff[2][i];
         end else begin
            job_in[0][i] = col_zero_ff ? win_ff[2][i] : win_ff[1][i];
            job_in[1][i] = win_ff[2][i];
            job_in[2][i] = win_ff[2][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff  <= 1'b0;
         need_a_ff <= 1'b0;
         need_b_ff <= 1'b0;
         job_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         job_v_ff  <= job_go;
         prod_v_ff <= job_v_ff;
         out_v_ff  <= prod_v_ff;
         if (cur_v_ff && need_a_ff && need_b_ff) begin
            need_a_ff <= 1'b0;
         end else if (pop) begin
            cur_v_ff  <= 1'b1;
            need_a_ff <= !q_ent.ctl.col_zero;
            need_b_ff <= q_ent.ctl.ends;
         end else begin
            cur_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         col_zero_ff <= q_ent.ctl.col_zero;
         col_one_ff  <= q_ent.ctl.col_one;
         drain_ff    <= q_ent.ctl.draining;
         win_ff[0]   <= win_ff[1];
         win_ff[1]   <= win_ff[2];
         win_ff[2][0] <= q_ent.top;
         win_ff[2][1] <= q_ent.mid;
         win_ff[2][2] <= q_ent.bot;
      end
      if (adv) begin
         job_ff       <= job_in;
         job_rend_ff  <= !need_a_ff;
         job_fend_ff  <= !need_a_ff && drain_ff;
         job_last_ff  <= !(need_a_ff && need_b_ff);
         prod_ff      <= prod_in;
         prod_rend_ff <= job_rend_ff;
         prod_fend_ff <= job_fend_ff;
         prod_last_ff <= job_last_ff;
         out_r_ff     <= clamp[0];
         out_g_ff     <= clamp[1];
         out_b_ff     <= clamp[2];
         out_rend_ff  <= prod_rend_ff;
         out_fend_ff  <= prod_fend_ff;
         out_last_ff  <= prod_last_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            kc[i][k] = kernel[i][k*COEFF_BITS +: COEFF_BITS];
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               prod_in[ch][i][k] = PW'($signed({1'b0, job_ff[k][i][8*ch +: 8]})) * PW'(kc[i][k]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               sum[ch] = sum[ch] + SW'(prod_ff[ch][i][k]);
            end
         end
         if (sum[ch] < 0) begin
            clamp[ch] = 8'd0;
         end else if (sum[ch] > SW'(255)) begin
            clamp[ch] = 8'd255;
         end else begin
            clamp[ch] = sum[ch][7:0];
         end
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.out_red   = out_r_ff;
   assign rsp_ch.out_green = out_g_ff;
   assign rsp_ch.out_blue  = out_b_ff;
   assign rsp_ch.row_end   = out_rend_ff;
   assign rsp_ch.frame_end = out_fend_ff;
   assign rsp_ch.run_last  = out_last_ff;

endmodule

// ===== rtl/cnv3_checker.sv =====
// Port-level checks on the response channel, bound to the top level.
module cnv3_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic       rsp_row_end,
   input logic       rsp_frame_end,
   input logic       rsp_run_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red))
      else $error("response beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_row_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_run_last)
      else $error("row end beat not last of its run");

endmodule

bind conv3x3_rgb_clamp_edge cnv3_checker u_chk (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_red       (rsp_ch.out_red),
   .rsp_row_end   (rsp_ch.row_end),
   .rsp_frame_end (rsp_ch.frame_end),
   .rsp_run_last  (rsp_ch.run_last)
);

// ===== tb/sv/tb_scoreboard.sv =====
// Convolution predictor and scoreboard for the 3x3 RGB filter testbench.
`timescale 1ns / 100ps
class conv_scoreboard;
   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       row_end;
      logic       frame_end;
      logic       run_last;
   } pix_out_t;

   logic [10:0] width_reg;
   logic [15:0] height_reg;
   logic [23:0] kern [3];
   logic [23:0] upper [1024];
   logic [23:0] lower [1024];
   logic [23:0] win [3][3];
   int unsigned col_cnt, row_cnt, drain_cnt;
   pix_out_t pending [$];
   int errors;

   function new();
      errors = 0;
      clear();
   endfunction

   function void clear();
      width_reg = 640;
      height_reg = 480;
      kern[0] = 0;
      kern[1] = 256;
      kern[2] = 0;
      foreach (upper[i]) begin
         upper[i] = 0;
         lower[i] = 0;
      end
      foreach (win[i, j]) win[i][j] = 0;
      col_cnt = 0;
      row_cnt = 0;
      drain_cnt = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
         cnv3_pkg::REG_FRAME_WIDTH: width_reg = val[10:0];
         cnv3_pkg::REG_FRAME_HEIGHT: height_reg = val[15:0];
         cnv3_pkg::REG_KERNEL_TOP: kern[0] = val;
         cnv3_pkg::REG_KERNEL_MIDDLE: kern[1] = val;
         cnv3_pkg::REG_KERNEL_BOTTOM: kern[2] = val;
         default: ;
      endcase
   endfunction

   function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > 1024) return 1024;
      return width_reg;
   endfunction

   function int eff_h();
      return height_reg == 0 ? 1 : height_reg;
   endfunction

   function void shift(logic [23:0] t, logic [23:0] m, logic [23:0] b);
      win[0] = win[1];
      win[1] = win[2];
      win[2][0] = t;
      win[2][1] = m;
      win[2][2] = b;
   endfunction

   function void filter(int lc, int cc, int rc, bit re, bit fe, bit lst);
      pix_out_t o;
      int cols [3];
      int s;
      logic signed [7:0] k;
      logic [23:0] p;
      cols = '{lc, cc, rc};
      for (int ch = 0; ch < 3; ch++) begin
         s = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               k = kern[i][8*j +: 8];
               p = win[cols[j]][i];
               s += int'(k) * int'({1'b0, p[8*ch +: 8]});
            end
         if (s < 0) s = 0;
         if (s > 255) s = 255;
         if (ch == 0) o.r = s[7:0];
         else if (ch == 1) o.g = s[7:0];
         else o.b = s[7:0];
      end
      o.row_end = re;
      o.frame_end = fe;
      o.run_last = lst;
      pending.push_back(o);
   endfunction

   function void produce(int c, int w, bit drn);
      bit ends;
      ends = (c >= w - 1);
      if (c >= 1) filter(c == 1 ? 1 : 0, 1, 2, 0, 0, !ends);
      if (ends) filter(c == 0 ? 2 : 1, 2, 2, 1, drn, 1);
   endfunction

   function void note_input(logic op, logic [23:0] px);
      int w, h, c;
      logic [23:0] t, m;
      w = eff_w();
      h = eff_h();
      if (op == cnv3_pkg::OP_PIXEL) begin
         c = col_cnt < 1024 ? col_cnt : 1023;
         if (row_cnt >= h) return;
         t = upper[c];
         m = lower[c];
         upper[c] = m;
         lower[c] = px;
         if (row_cnt >= 1) begin
            if (row_cnt == 1) t = m;
            shift(t, m, px);
            produce(c, w, 0);
         end
         if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt++;
         end else col_cnt = c + 1;
      end else begin
         c = drain_cnt < 1024 ? drain_cnt : 1023;
         if (row_cnt < h) return;
         t = upper[c];
         m = lower[c];
         if (row_cnt <= 1) t = m;
         shift(t, m, m);
         produce(c, w, 1);
         if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt = 0;
            drain_cnt = 0;
         end else drain_cnt = c + 1;
      end
   endfunction

   function void check_result(pix_out_t got);
      pix_out_t exp_v;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      exp_v = pending.pop_front();
      if (got.r !== exp_v.r) $display("%0t: red exp %h got %h", $time, exp_v.r, got.r);
      if (got.g !== exp_v.g) $display("%0t: green exp %h got %h", $time, exp_v.g, got.g);
      if (got.b !== exp_v.b) $display("%0t: blue exp %h got %h", $time, exp_v.b, got.b);
      if (got.row_end !== exp_v.row_end)
         $display("%0t: row_end exp %b got %b", $time, exp_v.row_end, got.row_end);
      if (got.frame_end !== exp_v.frame_end)
         $display("%0t: frame_end exp %b got %b", $time, exp_v.frame_end, got.frame_end);
      if (got.run_last !== exp_v.run_last)
         $display("%0t: run_last exp %b got %b", $time, exp_v.run_last, got.run_last);
      if (got !== exp_v) errors++;
   endfunction
endclass

// ===== tb/sv/tb.sv =====
// Top of the 3x3 RGB convolution testbench: stimulus, idling and result checking.
`timescale 1ns / 100ps
module tb;
   import cnv3_pkg::*;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   cnv3_req_if req_ch ();
   cnv3_rsp_if rsp_ch ();
   cnv3_csr_if #(.DATA_W(24)) csr_ch ();

   conv3x3_rgb_clamp_edge u_top (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   conv_scoreboard sb = new();
   int idle_cycles = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.operation = OP_PIXEL;
      req_ch.pixel_red = 0;
      req_ch.pixel_green = 0;
      req_ch.pixel_blue = 0;
      csr_ch.valid = 0;
      csr_ch.index = REG_FRAME_WIDTH;
      csr_ch.data = 0;
      rsp_ch.ready = 0;
   end

   // result side: random stalls, checking on accept
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result({rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue,
                             rsp_ch.row_end, rsp_ch.frame_end, rsp_ch.run_last});
         end
      end
   end

   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
         repeat (gap) begin
            rsp_ch.ready <= 0;
            @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("conv3x3_rgb_clamp_edge test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_beat(logic op, logic [23:0] px, bit bursty);
      int gap;
      gap = bursty ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.operation <= op;
      req_ch.pixel_red <= px[7:0];
      req_ch.pixel_green <= px[15:8];
      req_ch.pixel_blue <= px[23:16];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_input(op, px);
   endtask

   task automatic drain_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_px(int mode);
      case (mode)
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom_range(0, 24'hffffff));
      endcase
   endfunction

   function automatic logic [23:0] rand_kernel_row();
      logic [23:0] k;
      int m;
      m = $urandom_range(0, 5);
      for (int i = 0; i < 3; i++)
         k[8*i +: 8] = m == 0 ? 8'h80 : m == 1 ? 8'h7f : m < 4 ? 8'($urandom_range(0, 255))
                     : 8'(int'($urandom_range(0, 6)) - 3);
      return k;
   endfunction

   // one frame of w x h pixels plus drain, with optional noise beats
   task automatic run_frame(int w, int h, int pxmode, bit noisy, bit bursty);
      for (int i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_beat(OP_DRAIN, rand_px(2), bursty);
         send_beat(OP_PIXEL, rand_px(pxmode == 3 ? $urandom_range(0, 2) : pxmode), bursty);
      end
      for (int i = 0; i < w; i++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_beat(OP_PIXEL, rand_px(2), bursty);
         send_beat(OP_DRAIN, rand_px(2), bursty);
      end
   endtask

   task automatic set_size(int w, int h);
      write_reg(REG_FRAME_WIDTH, 24'(w));
      write_reg(REG_FRAME_HEIGHT, 24'(h));
   endtask

   initial begin
      int sent, w, h;
      logic [23:0] wraw;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: identity kernel, tiny frames, early drain ignored; then extreme kernel, extra pixel ignored
      set_size(3, 2);
      send_beat(OP_DRAIN, 24'h0, 0);
      run_frame(3, 2, 3, 0, 0);
      drain_idle();
      set_size(0, 0);
      run_frame(1, 1, 1, 0, 1);
      drain_idle();
      write_reg(REG_KERNEL_TOP, 24'h808080);
      write_reg(REG_KERNEL_MIDDLE, 24'h7f7f7f);
      write_reg(REG_KERNEL_BOTTOM, 24'h010203);
      set_size(2, 3);
      send_beat(OP_PIXEL, 24'hffffff, 0);
      send_beat(OP_PIXEL, 24'h000000, 0);
      send_beat(OP_PIXEL, 24'h00ff00, 0);
      send_beat(OP_PIXEL, 24'hff00ff, 0);
      send_beat(OP_PIXEL, 24'h123456, 0);
      send_beat(OP_PIXEL, 24'hfedcba, 0);
      send_beat(OP_PIXEL, 24'h555555, 0);
      send_beat(OP_DRAIN, 24'h0, 0);
      send_beat(OP_DRAIN, 24'h0, 0);
      drain_idle();
      // random phases
      sent = 0;
      while (sent < 1380) begin
         w = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
         h = $urandom_range(1, 5);
         wraw = 24'(w);
         if ($urandom_range(0, 7) == 0) h = 16'hffff;
         write_reg(REG_FRAME_WIDTH, wraw);
         write_reg(REG_FRAME_HEIGHT, 24'(h == 16'hffff ? 1 : h));
         if (h == 16'hffff) h = 1;
         write_reg(REG_KERNEL_TOP, rand_kernel_row());
         write_reg(REG_KERNEL_MIDDLE, rand_kernel_row());
         write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
         run_frame(w, h, 3, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
         sent += w * h + w;
         drain_idle();
      end
      write_reg(REG_FRAME_HEIGHT, 24'hffff);
      if (sb.errors == 0) $display("conv3x3_rgb_clamp_edge test passed");
      else $display("conv3x3_rgb_clamp_edge test failed");
      $finish;
   end
endmodule
